FILE: rtl/ucfr_pkg.sv
// Package for the UART command frame receiver: opcodes, register indexes,
// frame lengths and register reset values. No dependencies.
`default_nettype none

package ucfr_pkg;

   // Frame lengths in bytes.
   localparam int FrameMax = 7;
   localparam int FrameCmd = 3;

   // Width of the byte counter and of the configuration address.
   localparam int CountWidth = 3;
   localparam int AddrWidth  = 5;

   // Reset values of the configuration registers.
   localparam logic [7:0]  HeadReset      = 8'd170;
   localparam logic [7:0]  TailReset      = 8'd85;
   localparam logic [7:0]  ActCodeReset   = 8'd16;
   localparam logic [7:0]  HeartReset     = 8'd255;
   localparam logic [7:0]  MaxCmdReset    = 8'd8;
   localparam logic [15:0] PeriodReset    = 16'd1000;
   localparam logic [19:0] TimeoutReset   = 20'd30000;
   localparam logic [15:0] WaitReset      = 16'd5000;

   typedef enum logic [1:0] {
      OpByte     = 2'd0,
      OpTick     = 2'd1,
      OpResetReq = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      RegHead    = 3'd0,
      RegTail    = 3'd1,
      RegActCode = 3'd2,
      RegHeart   = 3'd3,
      RegMaxCmd  = 3'd4,
      RegPeriod  = 3'd5,
      RegTimeout = 3'd6,
      RegWait    = 3'd7
   } reg_index_type;

endpackage

`default_nettype wire

FILE: rtl/ucfr_if.sv
// Valid/ready channel interfaces for the UART command frame receiver:
// the input item channel and the result channel. Depends on ucfr_pkg.
`default_nettype none

interface ucfr_req_if;
   import ucfr_pkg::*;

   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [7:0]  rx_byte;
   logic [31:0] now_ms;

   modport source (output valid, output opcode, output rx_byte, output now_ms,
                   input ready);
   modport sink   (input valid, input opcode, input rx_byte, input now_ms,
                   output ready);
endinterface

interface ucfr_rsp_if;
   import ucfr_pkg::*;

   logic       valid;
   logic       ready;
   logic       command_strobe;
   logic [7:0] command_code;
   logic       actuator_strobe;
   logic       power1_target;
   logic       power2_target;
   logic       fan_target;
   logic       alarm_flag;
   logic       link_online;
   logic       reset_pending;
   logic       status_due;

   modport source (output valid, output command_strobe, output command_code,
                   output actuator_strobe, output power1_target,
                   output power2_target, output fan_target, output alarm_flag,
                   output link_online, output reset_pending, output status_due,
                   input ready);
   modport sink   (input valid, input command_strobe, input command_code,
                   input actuator_strobe, input power1_target,
                   input power2_target, input fan_target, input alarm_flag,
                   input link_online, input reset_pending, input status_due,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/uart_command_frame_receiver.sv
// The result of an accepted input transaction is in the output register in the
// next cycle. Throughput: one transaction per cycle; the result register
// is the only stage, so a new transaction is taken whenever it is empty or
// being drained in the same cycle. Reset (synchronous, active high) empties
// the result register, clears the frame search, timers and held targets, and
// loads the configuration registers with their default values.
// Depends on ucfr_pkg and the channel interfaces in ucfr_if.sv.
`default_nettype none

module uart_command_frame_receiver (
   input  wire logic                            clock,
   input  wire logic                            reset,
   ucfr_req_if.sink                             req_chan,
   ucfr_rsp_if.source                           rsp_chan,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [ucfr_pkg::AddrWidth-1:0]  paddr,
   input  wire logic [31:0]                     pwdata,
   output logic      [31:0]                     prdata,
   output logic                                 pready
);
   import ucfr_pkg::*;

   // Configuration registers.
   logic [7:0]  head_ff, tail_ff, act_code_ff, heart_ff, max_cmd_ff;
   logic [15:0] period_ff, wait_ff;
   logic [19:0] timeout_ff;

   // Receiver state.
   logic [7:0]            store_ff [FrameMax];
   logic [7:0]            store_in [FrameMax];
   logic [CountWidth-1:0] count_ff, count_in;
   logic [31:0]           last_good_ff, last_good_in;
   logic [31:0]           last_status_ff, last_status_in;
   logic                  reset_flag_ff, reset_flag_in;
   logic [31:0]           reset_req_ff, reset_req_in;
   logic [7:0]            held_cmd_ff, held_cmd_in;
   logic [3:0]            act_bits_ff, act_bits_in;

   // Result register.
   logic       rsp_valid_ff;
   logic       cmd_strobe_ff, cmd_strobe_in;
   logic       act_strobe_ff, act_strobe_in;
   logic       online_ff, online_in;
   logic       due_ff, due_in;

   logic        accept;
   logic        cfg_write;
   logic [2:0]  cfg_index;
   logic [7:0]  b;
   logic [31:0] now;
   logic [CountWidth-1:0] next_count;
   logic [7:0]  s1, s2;
   logic        good;
   logic        code_valid;
   logic [31:0] good_age, wait_age, status_age;

   // A transaction enters whenever the result register is free or its
   // content leaves in this same cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign cfg_index = paddr[AddrWidth-1:2];

   assign b   = req_chan.rx_byte;
   assign now = req_chan.now_ms;

   assign next_count = count_ff + 1'b1;

   // The frame store as it looks once the new byte has been placed.
   assign s1 = (count_ff == CountWidth'(1)) ? b : store_ff[1];
   assign s2 = (count_ff == CountWidth'(2)) ? b : store_ff[2];

   assign code_valid = (s1 <= max_cmd_ff) || (s1 == heart_ff);

   assign good_age   = now - last_good_ff;
   assign wait_age   = now - reset_req_ff;
   assign status_age = now - last_status_ff;

   always_comb begin
      store_in       = store_ff;
      count_in       = count_ff;
      last_good_in   = last_good_ff;
      last_status_in = last_status_ff;
      reset_flag_in  = reset_flag_ff;
      reset_req_in   = reset_req_ff;
      held_cmd_in    = held_cmd_ff;
      act_bits_in    = act_bits_ff;
      cmd_strobe_in  = 1'b0;
      act_strobe_in  = 1'b0;
      due_in         = 1'b0;
      good           = 1'b0;

      case (req_chan.opcode)
         OpByte: begin
            if (count_ff == '0) begin
               // No frame open: only a head byte starts one.
               if (b == head_ff) begin
                  store_in[0] = b;
                  count_in    = CountWidth'(1);
               end
            end else if (count_ff == CountWidth'(FrameMax)) begin
               count_in = '0;
            end else begin
               for (int i = 1; i < FrameMax; i++) begin
                  if (count_ff == CountWidth'(i)) begin
                     store_in[i] = b;
                  end
               end
               count_in = next_count;
               if (next_count >= CountWidth'(2) && s1 == act_code_ff &&
                   next_count < CountWidth'(FrameMax)) begin
                  // Actuator frame still gathering its bytes.
               end else if (next_count == CountWidth'(FrameMax) &&
                            store_ff[0] == head_ff && s1 == act_code_ff &&
                            b == tail_ff) begin
                  good          = 1'b1;
                  act_strobe_in = 1'b1;
                  reset_flag_in = 1'b0;
                  count_in      = '0;
                  act_bits_in   = {store_ff[5] != 8'd0, store_ff[4] != 8'd0,
                                   store_ff[3] != 8'd0, store_ff[2] != 8'd0};
               end else if (next_count < CountWidth'(FrameCmd)) begin
                  // Command frame still needs its tail.
               end else begin
                  // Judge the bytes as a command frame, then search again.
                  if (store_ff[0] == head_ff && s2 == tail_ff && code_valid) begin
                     good = 1'b1;
                     if (s1 != heart_ff && !reset_flag_ff) begin
                        held_cmd_in   = s1;
                        cmd_strobe_in = 1'b1;
                     end
                  end
                  count_in = '0;
                  if (b == head_ff) begin
                     store_in[0] = b;
                     count_in    = CountWidth'(1);
                  end
               end
            end
         end
         OpTick: begin
            if (reset_flag_ff && wait_age >= {16'd0, wait_ff}) begin
               reset_flag_in = 1'b0;
            end
            if (status_age >= {16'd0, period_ff}) begin
               last_status_in = now;
               due_in         = 1'b1;
            end
         end
         OpResetReq: begin
            reset_flag_in = 1'b1;
            reset_req_in  = now;
         end
         default: begin
            // The unused opcode leaves every piece of state alone.
         end
      endcase

      if (good) begin
         last_good_in = now;
      end
      // A good frame in this transaction makes the age zero, which is
      // always within the timeout.
      online_in = good || (good_age <= {12'd0, timeout_ff});
   end

   // Receiver state and the result register advance on each accepted
   // transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FrameMax; i++) begin
            store_ff[i] <= '0;
         end
         count_ff       <= '0;
         last_good_ff   <= '0;
         last_status_ff <= '0;
         reset_flag_ff  <= 1'b0;
         reset_req_ff   <= '0;
         held_cmd_ff    <= '0;
         act_bits_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            store_ff       <= store_in;
            count_ff       <= count_in;
            last_good_ff   <= last_good_in;
            last_status_ff <= last_status_in;
            reset_flag_ff  <= reset_flag_in;
            reset_req_ff   <= reset_req_in;
            held_cmd_ff    <= held_cmd_in;
            act_bits_ff    <= act_bits_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // The strobes and link status travel with the result; they need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_strobe_ff <= cmd_strobe_in;
         act_strobe_ff <= act_strobe_in;
         online_ff     <= online_in;
         due_ff        <= due_in;
      end
   end

   // Held values are reported straight from the state, which only changes
   // when the next transaction is accepted, i.e. when this result leaves.
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.command_strobe  = cmd_strobe_ff;
   assign rsp_chan.command_code    = held_cmd_ff;
   assign rsp_chan.actuator_strobe = act_strobe_ff;
   assign rsp_chan.power1_target   = act_bits_ff[0];
   assign rsp_chan.power2_target   = act_bits_ff[1];
   assign rsp_chan.fan_target      = act_bits_ff[2];
   assign rsp_chan.alarm_flag      = act_bits_ff[3];
   assign rsp_chan.link_online     = online_ff;
   assign rsp_chan.reset_pending   = reset_flag_ff;
   assign rsp_chan.status_due      = due_ff;

   // Configuration registers are written in the access phase of a write.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= HeadReset;
         tail_ff     <= TailReset;
         act_code_ff <= ActCodeReset;
         heart_ff    <= HeartReset;
         max_cmd_ff  <= MaxCmdReset;
         period_ff   <= PeriodReset;
         timeout_ff  <= TimeoutReset;
         wait_ff     <= WaitReset;
      end else if (cfg_write) begin
         case (cfg_index)
            RegHead:    head_ff     <= pwdata[7:0];
            RegTail:    tail_ff     <= pwdata[7:0];
            RegActCode: act_code_ff <= pwdata[7:0];
            RegHeart:   heart_ff    <= pwdata[7:0];
            RegMaxCmd:  max_cmd_ff  <= pwdata[7:0];
            RegPeriod:  period_ff   <= pwdata[15:0];
            RegTimeout: timeout_ff  <= pwdata[19:0];
            RegWait:    wait_ff     <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (cfg_index)
         RegHead:    prdata = {24'd0, head_ff};
         RegTail:    prdata = {24'd0, tail_ff};
         RegActCode: prdata = {24'd0, act_code_ff};
         RegHeart:   prdata = {24'd0, heart_ff};
         RegMaxCmd:  prdata = {24'd0, max_cmd_ff};
         RegPeriod:  prdata = {16'd0, period_ff};
         RegTimeout: prdata = {12'd0, timeout_ff};
         RegWait:    prdata = {16'd0, wait_ff};
         default:    prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: tb/ucfr_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the UART command frame receiver: watches the input, result
// and configuration ports, predicts every result and compares it in order.
// Depends on ucfr_pkg and the channel interfaces in ucfr_if.sv.

module ucfr_result_checker (
   input  logic                           clock,
   input  logic                           reset,
   ucfr_req_if                            req_mon,
   ucfr_rsp_if                            rsp_mon,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ucfr_pkg::AddrWidth-1:0] paddr,
   input  logic [31:0]                    pwdata,
   input  logic                           pready,
   output int                             fail_count,
   output int                             pending_results
);
   import ucfr_pkg::*;

   typedef struct packed {
      logic       command_strobe;
      logic [7:0] command_code;
      logic       actuator_strobe;
      logic       power1_target;
      logic       power2_target;
      logic       fan_target;
      logic       alarm_flag;
      logic       link_online;
      logic       reset_pending;
      logic       status_due;
   } frame_result_type;

   // Shadow copy of the configuration registers.
   logic [7:0]  cfg_head;
   logic [7:0]  cfg_tail;
   logic [7:0]  cfg_act;
   logic [7:0]  cfg_heart;
   logic [7:0]  cfg_max;
   logic [15:0] cfg_period;
   logic [19:0] cfg_timeout;
   logic [15:0] cfg_wait;

   // Shadow copy of the frame search, timers and held outputs.
   logic [7:0]  frame_buf [FrameMax];
   int          frame_len;
   logic [31:0] link_seen_ms;
   logic [31:0] status_sent_ms;
   logic        reset_hold;
   logic [31:0] reset_hold_ms;
   logic [7:0]  held_code;
   logic [3:0]  targets;

   frame_result_type expected_results [$];
   int               results_seen;

   function automatic string describe_result(input frame_result_type r);
      return $sformatf("cmd=%0b code=%02h act=%0b targets=%b%b%b%b online=%0b pending=%0b due=%0b",
                       r.command_strobe, r.command_code, r.actuator_strobe, r.power1_target,
                       r.power2_target, r.fan_target, r.alarm_flag, r.link_online,
                       r.reset_pending, r.status_due);
   endfunction

   function automatic frame_result_type predict_frame_result(input logic [1:0] op,
                                                             input logic [7:0] b,
                                                             input logic [31:0] now);
      frame_result_type result;
      logic             cmd;
      logic             act;
      logic             due;
      logic             gathering;
      int               i;
      cmd = 1'b0;
      act = 1'b0;
      due = 1'b0;
      case (op)
         OpByte: begin
            if (frame_len == 0) begin
               if (b == cfg_head) begin
                  frame_buf[0] = b;
                  frame_len = 1;
               end
            end else if (frame_len >= FrameMax) begin
               frame_len = 0;
            end else begin
               frame_buf[frame_len] = b;
               frame_len++;
               // An actuator frame keeps gathering until all seven bytes are in.
               gathering = (frame_len < FrameMax) && (frame_buf[1] == cfg_act);
               if (!gathering) begin
                  if (frame_len == FrameMax && frame_buf[0] == cfg_head &&
                      frame_buf[1] == cfg_act && frame_buf[6] == cfg_tail) begin
                     for (i = 0; i < 4; i++)
                        targets[i] = (frame_buf[2 + i] != 8'd0);
                     link_seen_ms = now;
                     reset_hold = 1'b0;
                     frame_len = 0;
                     act = 1'b1;
                  end else if (frame_len >= FrameCmd) begin
                     // Judged as a command frame, also when a long frame went bad.
                     if (frame_buf[0] == cfg_head && frame_buf[2] == cfg_tail &&
                         (frame_buf[1] <= cfg_max || frame_buf[1] == cfg_heart)) begin
                        link_seen_ms = now;
                        if (frame_buf[1] != cfg_heart && !reset_hold) begin
                           held_code = frame_buf[1];
                           cmd = 1'b1;
                        end
                     end
                     frame_len = 0;
                     if (b == cfg_head) begin
                        frame_buf[0] = b;
                        frame_len = 1;
                     end
                  end
               end
            end
         end
         OpTick: begin
            if (reset_hold && (now - reset_hold_ms) >= {16'd0, cfg_wait})
               reset_hold = 1'b0;
            if ((now - status_sent_ms) >= {16'd0, cfg_period}) begin
               status_sent_ms = now;
               due = 1'b1;
            end
         end
         OpResetReq: begin
            reset_hold = 1'b1;
            reset_hold_ms = now;
         end
         default: begin
         end
      endcase
      result.command_strobe  = cmd;
      result.command_code    = held_code;
      result.actuator_strobe = act;
      result.power1_target   = targets[0];
      result.power2_target   = targets[1];
      result.fan_target      = targets[2];
      result.alarm_flag      = targets[3];
      result.link_online     = ((now - link_seen_ms) <= {12'd0, cfg_timeout});
      result.reset_pending   = reset_hold;
      result.status_due      = due;
      return result;
   endfunction

   always @(posedge clock) begin : monitor
      frame_result_type seen;
      frame_result_type want;
      int               i;
      if (reset) begin
         cfg_head       = HeadReset;
         cfg_tail       = TailReset;
         cfg_act        = ActCodeReset;
         cfg_heart      = HeartReset;
         cfg_max        = MaxCmdReset;
         cfg_period     = PeriodReset;
         cfg_timeout    = TimeoutReset;
         cfg_wait       = WaitReset;
         for (i = 0; i < FrameMax; i++)
            frame_buf[i] = 8'd0;
         frame_len      = 0;
         link_seen_ms   = 32'd0;
         status_sent_ms = 32'd0;
         reset_hold     = 1'b0;
         reset_hold_ms  = 32'd0;
         held_code      = 8'd0;
         targets        = 4'd0;
         results_seen   = 0;
         fail_count     = 0;
         expected_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[AddrWidth-1:2]))
               RegHead:    cfg_head    = pwdata[7:0];
               RegTail:    cfg_tail    = pwdata[7:0];
               RegActCode: cfg_act     = pwdata[7:0];
               RegHeart:   cfg_heart   = pwdata[7:0];
               RegMaxCmd:  cfg_max     = pwdata[7:0];
               RegPeriod:  cfg_period  = pwdata[15:0];
               RegTimeout: cfg_timeout = pwdata[19:0];
               RegWait:    cfg_wait    = pwdata[15:0];
               default: begin
               end
            endcase
         end
         // Results are checked before this edge's input is predicted: a result
         // can never leave in the same cycle as its own input transaction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            results_seen++;
            seen = {rsp_mon.command_strobe, rsp_mon.command_code, rsp_mon.actuator_strobe,
                    rsp_mon.power1_target, rsp_mon.power2_target, rsp_mon.fan_target,
                    rsp_mon.alarm_flag, rsp_mon.link_online, rsp_mon.reset_pending,
                    rsp_mon.status_due};
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("result %0d arrived with nothing expected: %s",
                           results_seen, describe_result(seen));
            end else begin
               want = expected_results.pop_front();
               if (seen !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch on result %0d: expected %s, actual %s",
                              results_seen, describe_result(want), describe_result(seen));
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(predict_frame_result(req_mon.opcode, req_mon.rx_byte,
                                                            req_mon.now_ms));
      end
      pending_results = expected_results.size();
   end

endmodule

FILE: tb/tb_uart_command_frame_receiver.sv
`timescale 1ns / 100ps
// Top of the UART command frame receiver testbench: clock, reset, stimulus,
// register writes and the verdict. Depends on ucfr_pkg, ucfr_if.sv and the checker.

module tb_uart_command_frame_receiver;
   import ucfr_pkg::*;

   // The spare opcode value has no name in the package; it must change nothing.
   localparam logic [1:0] OpUnused = 2'd3;

   localparam int PhaseCount    = 8;
   localparam int ItemsPerPhase = 185;
   localparam int HoldCycles    = 200;
   localparam int CycleLimit    = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ucfr_req_if req_chan_if ();
   ucfr_rsp_if rsp_chan_if ();

   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [AddrWidth-1:0] paddr;
   logic [31:0]          pwdata;
   logic [31:0]          prdata;
   logic                 pready;

   int fail_count;
   int pending_results;

   // Stimulus-side copy of the configuration. The frame generator needs it to
   // build well-formed frames; the checker keeps its own copy from the port.
   logic [7:0]  cfg_head    = HeadReset;
   logic [7:0]  cfg_tail    = TailReset;
   logic [7:0]  cfg_act     = ActCodeReset;
   logic [7:0]  cfg_heart   = HeartReset;
   logic [7:0]  cfg_max     = MaxCmdReset;
   logic [15:0] cfg_period  = PeriodReset;
   logic [19:0] cfg_timeout = TimeoutReset;
   logic [15:0] cfg_wait    = WaitReset;

   logic [31:0] stim_now           = 32'd0;
   logic        random_time        = 1'b0;
   int          sender_idle_pct    = 0;
   int          receiver_stall_pct = 0;
   int          hold_requests      = 0;
   int          items_sent         = 0;

   // 8 ns period: high for 4, low for 4.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   uart_command_frame_receiver uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan_if),
      .rsp_chan (rsp_chan_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   ucfr_result_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan_if),
      .rsp_mon         (rsp_chan_if),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .pready          (pready),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // Offers one input transaction at a falling edge and returns at the falling
   // edge after it was accepted. Idle cycles are drawn one at a time, so gaps
   // land anywhere inside a frame. In the random part each transaction also
   // moves the clock of the stimulus: mostly small steps, sometimes a jump
   // past the status period or reset wait, now and then past the link timeout,
   // and rarely a completely random time so that every bit of now_ms toggles.
   task automatic send_item(input logic [1:0] op, input logic [7:0] b);
      int pick;
      if (random_time) begin
         pick = $urandom_range(99);
         if (pick < 80)
            stim_now += $urandom_range(0, 5);
         else if (pick < 92)
            stim_now += $urandom_range(0, int'(cfg_period) + int'(cfg_wait) + 1);
         else if (pick < 98)
            stim_now += $urandom_range(0, 2 * int'(cfg_timeout) + 2);
         else
            stim_now = $urandom;
      end
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan_if.valid   <= 1'b1;
      req_chan_if.opcode  <= op;
      req_chan_if.rx_byte <= b;
      req_chan_if.now_ms  <= stim_now;
      @(posedge clock);
      while (!req_chan_if.ready)
         @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_command_frame(input logic [7:0] code, input logic [7:0] tail);
      send_item(OpByte, cfg_head);
      send_item(OpByte, code);
      send_item(OpByte, tail);
   endtask

   task automatic send_actuator_frame(input logic [7:0] t0, input logic [7:0] t1,
                                      input logic [7:0] t2, input logic [7:0] t3,
                                      input logic [7:0] tail);
      send_item(OpByte, cfg_head);
      send_item(OpByte, cfg_act);
      send_item(OpByte, t0);
      send_item(OpByte, t1);
      send_item(OpByte, t2);
      send_item(OpByte, t3);
      send_item(OpByte, tail);
   endtask

   // Mostly well-formed frames with random content, since only those get the
   // frame search past its first byte; the rest is ticks, reset requests, the
   // spare opcode, frames cut short and loose bytes.
   task automatic send_random_sequence();
      int         pick;
      int         n;
      int         i;
      logic [7:0] code;
      logic [7:0] tail;
      logic [7:0] t [4];
      pick = $urandom_range(99);
      if (pick < 35) begin
         n = $urandom_range(99);
         if (n < 50)
            code = 8'($urandom_range(0, int'(cfg_max)));
         else if (n < 65)
            code = cfg_heart;
         else if (n < 75)
            code = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
         else
            code = 8'($urandom_range(0, 255));
         tail = ($urandom_range(99) < 90) ? cfg_tail : 8'($urandom_range(0, 255));
         send_command_frame(code, tail);
      end else if (pick < 55) begin
         for (i = 0; i < 4; i++)
            t[i] = ($urandom_range(1) != 0) ? 8'd0 : 8'($urandom_range(1, 255));
         tail = ($urandom_range(99) < 80) ? cfg_tail : 8'($urandom_range(0, 255));
         send_actuator_frame(t[0], t[1], t[2], t[3], tail);
      end else if (pick < 73) begin
         send_item(OpTick, 8'($urandom_range(0, 255)));
      end else if (pick < 79) begin
         send_item(OpResetReq, 8'($urandom_range(0, 255)));
      end else if (pick < 81) begin
         send_item(OpUnused, 8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
         // A frame that breaks off; whatever follows lands mid-frame.
         send_item(OpByte, cfg_head);
         if ($urandom_range(1) != 0)
            send_item(OpByte, cfg_act);
         n = $urandom_range(0, 3);
         repeat (n) send_item(OpByte, 8'($urandom_range(0, 255)));
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) send_item(OpByte, 8'($urandom_range(0, 255)));
      end
   endtask

   // Register write: setup cycle, then access cycle until pready. An idle
   // gap at the end keeps psel from being lowered and raised in one step.
   task automatic write_register(input reg_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_all_registers();
      write_register(RegHead,    {24'd0, cfg_head});
      write_register(RegTail,    {24'd0, cfg_tail});
      write_register(RegActCode, {24'd0, cfg_act});
      write_register(RegHeart,   {24'd0, cfg_heart});
      write_register(RegMaxCmd,  {24'd0, cfg_max});
      write_register(RegPeriod,  {16'd0, cfg_period});
      write_register(RegTimeout, {12'd0, cfg_timeout});
      write_register(RegWait,    {16'd0, cfg_wait});
   endtask

   // Stops offering and waits until every expected result has been taken,
   // then lets the result register settle before anything else happens.
   task automatic drain_results();
      req_chan_if.valid <= 1'b0;
      while (pending_results != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // Result side: random stalls by phase, plus long hold-offs on request. A
   // hold-off is counted here while the sender keeps offering, so the result
   // register fills and the block has to stall its input.
   initial begin : result_sink
      int hold_left;
      int holds_served;
      hold_left          = 0;
      holds_served       = 0;
      rsp_chan_if.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served < hold_requests) begin
            holds_served++;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan_if.ready <= 1'b0;
         end else begin
            rsp_chan_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // The run ends here if the block stops making progress.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int phase_start;
      bit hold_done;
      req_chan_if.valid   = 1'b0;
      req_chan_if.opcode  = OpByte;
      req_chan_if.rx_byte = 8'd0;
      req_chan_if.now_ms  = 32'd0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = 32'd0;

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, run on the reset configuration with no idling.
      stim_now = 32'd100;
      // Loose bytes with no frame open are dropped.
      send_item(OpByte, 8'h00);
      send_item(OpByte, 8'hFF);
      // The safe command, then a frame with a bad code whose third byte is a
      // head byte: that byte opens the next frame, which carries the highest
      // ordinary code.
      send_command_frame(8'h00, cfg_tail);
      send_item(OpByte, cfg_head);
      send_item(OpByte, cfg_max + 8'd1);
      send_command_frame(cfg_max, cfg_tail);
      // A heartbeat only refreshes the link time.
      send_command_frame(cfg_heart, cfg_tail);
      // A pending reset blocks the next command until a tick expires it; that
      // tick also finds the status period elapsed.
      stim_now = 32'd200;
      send_item(OpResetReq, 8'h00);
      send_command_frame(8'h05, cfg_tail);
      stim_now = 32'd200 + 32'(cfg_wait);
      send_item(OpTick, 8'h00);
      // An actuator frame sets the targets and clears a fresh pending reset.
      send_item(OpResetReq, 8'h00);
      send_actuator_frame(8'h01, 8'h00, 8'hFF, 8'h00, cfg_tail);
      // The spare opcode changes nothing.
      send_item(OpUnused, 8'hA5);

      // Random part: one register setting and one idling pattern per phase.
      random_time = 1'b1;
      for (phase = 0; phase < PhaseCount; phase++) begin
         drain_results();
         case (phase)
            0: begin
               // Reset values written back explicitly.
               cfg_head    = HeadReset;
               cfg_tail    = TailReset;
               cfg_act     = ActCodeReset;
               cfg_heart   = HeartReset;
               cfg_max     = MaxCmdReset;
               cfg_period  = PeriodReset;
               cfg_timeout = TimeoutReset;
               cfg_wait    = WaitReset;
            end
            1: begin
               cfg_head    = 8'h00;
               cfg_tail    = 8'hFF;
               cfg_act     = 8'h01;
               cfg_heart   = 8'h00;
               cfg_max     = 8'h00;
               cfg_period  = 16'd1;
               cfg_timeout = 20'd1;
               cfg_wait    = 16'd1;
            end
            2: begin
               cfg_head    = 8'hFF;
               cfg_tail    = 8'h00;
               cfg_act     = 8'hFE;
               cfg_heart   = 8'h80;
               cfg_max     = 8'hFF;
               cfg_period  = 16'hFFFF;
               cfg_timeout = 20'd1000000;
               cfg_wait    = 16'hFFFF;
            end
            default: begin
               cfg_head    = 8'($urandom_range(0, 255));
               cfg_tail    = 8'($urandom_range(0, 255));
               cfg_act     = 8'($urandom_range(0, 255));
               cfg_heart   = 8'($urandom_range(0, 255));
               cfg_max     = 8'($urandom_range(0, 255));
               cfg_period  = 16'($urandom_range(1, 3000));
               cfg_timeout = 20'($urandom_range(1, 60000));
               cfg_wait    = 16'($urandom_range(1, 6000));
               // Zero intervals count as elapsed on every tick.
               if (phase == 3) begin
                  cfg_period = 16'd0;
                  cfg_wait   = 16'd0;
               end
            end
         endcase
         write_all_registers();

         case (phase % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 66;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 66;
            end
            default: begin
               sender_idle_pct    = 35;
               receiver_stall_pct = 35;
            end
         endcase

         // Let the millisecond time wrap through zero during this phase.
         if (phase == 2)
            stim_now = 32'hFFFF_F800;

         phase_start = items_sent;
         hold_done   = 1'b0;
         while (items_sent - phase_start < ItemsPerPhase) begin
            if (!hold_done && (phase % 4 == 0) && (items_sent - phase_start >= 60)) begin
               hold_requests++;
               hold_done = 1'b1;
            end
            send_random_sequence();
         end
      end

      drain_results();
      repeat (4) @(negedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/ucfr_pkg.sv
rtl/ucfr_if.sv
rtl/uart_command_frame_receiver.sv
tb/ucfr_result_checker.sv
tb/tb_uart_command_frame_receiver.sv
